[sv/dsp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared types and constants of the subpicture stream parser.
// ----------------------------------------------------------------------------
package dsp_pkg;

  // Event kinds reported on the result queue.
  localparam logic [3:0] EV_PRIV1   = 4'd0;
  localparam logic [3:0] EV_SUBID   = 4'd1;
  localparam logic [3:0] EV_SPUSIZE = 4'd2;
  localparam logic [3:0] EV_DSIZE   = 4'd3;
  localparam logic [3:0] EV_DATA    = 4'd4;
  localparam logic [3:0] EV_SEQ     = 4'd5;
  localparam logic [3:0] EV_DISPLAY = 4'd6;
  localparam logic [3:0] EV_STOP    = 4'd7;
  localparam logic [3:0] EV_COLORS  = 4'd8;
  localparam logic [3:0] EV_CONTR   = 4'd9;
  localparam logic [3:0] EV_AREA    = 4'd10;
  localparam logic [3:0] EV_PIXOFS  = 4'd11;
  localparam logic [3:0] EV_COLCON  = 4'd12;
  localparam logic [3:0] EV_SEQEND  = 4'd13;
  localparam logic [3:0] EV_UNKNOWN = 4'd14;
  localparam logic [3:0] EV_ERROR   = 4'd15;

  // Error codes.
  localparam logic [15:0] ERR_SPU_ZERO   = 16'd1;
  localparam logic [15:0] ERR_DATA_SMALL = 16'd2;

  // Stream ids and control commands.
  localparam logic [7:0] SID_PRIV1   = 8'hBD;
  localparam logic [7:0] CMD_DISPLAY = 8'h01;
  localparam logic [7:0] CMD_STOP    = 8'h02;
  localparam logic [7:0] CMD_COLORS  = 8'h03;
  localparam logic [7:0] CMD_CONTR   = 8'h04;
  localparam logic [7:0] CMD_AREA    = 8'h05;
  localparam logic [7:0] CMD_PIXOFS  = 8'h06;
  localparam logic [7:0] CMD_COLCON  = 8'h07;
  localparam logic [7:0] CMD_END     = 8'hFF;

  // One result event.
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [15:0] d;
    logic        last;
  } event_t;

  // Parameter byte count of a command; zero for commands with none.
  function automatic logic [2:0] param_len(input logic [7:0] cmd);
    case (cmd)
      CMD_COLORS, CMD_CONTR, CMD_COLCON: param_len = 3'd2;
      CMD_AREA:   param_len = 3'd6;
      CMD_PIXOFS: param_len = 3'd4;
      default:    param_len = 3'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

[sv/dvd_subpicture_stream_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dvd_subpicture_stream_parser
// Program stream byte parser reporting subpicture unit events.
// ----------------------------------------------------------------------------
// One byte is taken per clock while full is low. Each byte is parsed
// combinationally by the front parser, whose event (if any) is registered and
// written to a four-entry queue the next cycle; events reach the result
// ports via the parser register and the queue. full rises when the queue
// cannot absorb another in-flight event, so a stalled reader throttles the input.
module dvd_subpicture_stream_parser #(
  parameter int QueueDepth = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  stream_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       event_kind,
  output logic [15:0]      param_a,
  output logic [15:0]      param_b,
  output logic [15:0]      param_c,
  output logic [15:0]      param_d,
  output logic             last_sequence
);
  import dsp_pkg::*;

  event_t ev, head;
  logic   ev_valid, almost_full;

  assign full = almost_full;

  dsp_front u_front (
    .clk(clk), .rst(rst), .byte_valid(push && !full), .byte_in(stream_byte),
    .ev(ev), .ev_valid(ev_valid)
  );

  dsp_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst), .wr_en(ev_valid), .wr_data(ev),
    .almost_full(almost_full), .empty(empty), .rd_en(pop), .rd_data(head)
  );

  assign event_kind    = head.kind;
  assign param_a       = head.a;
  assign param_b       = head.b;
  assign param_c       = head.c;
  assign param_d       = head.d;
  assign last_sequence = head.last;

endmodule
`default_nettype wire

[sv/dsp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_front
// Byte parser: follows the stream phase by phase and produces at most one
// event per accepted byte.
// ----------------------------------------------------------------------------
module dsp_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           byte_valid,
  input  wire logic [7:0]     byte_in,
  output dsp_pkg::event_t     ev,
  output logic                ev_valid
);
  import dsp_pkg::*;

  typedef enum logic [3:0] {
    PH_SCAN, PH_PESHDR, PH_HDRSKIP, PH_SUBID, PH_SPUSIZE, PH_DATASIZE,
    PH_DATA, PH_SEQHDR, PH_CMD, PH_CMDPAR, PH_COLSKIP
  } phase_t;

  phase_t      phase, phase_next;
  logic [23:0] window, window_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [15:0] skip_remaining, skip_remaining_next;
  logic [15:0] spu_position, spu_position_next;
  logic [15:0] data_size, data_size_next;
  logic [15:0] seq_start, seq_start_next;
  logic        is_last, is_last_next;
  logic [47:0] collect, collect_next;
  logic [7:0]  command, command_next;
  event_t      ev_next;
  logic        ev_valid_next;

  // Collected bytes including the current one, newest lowest.
  logic [47:0] col;
  logic [2:0]  count_inc;
  logic [15:0] skip_dec;

  always_comb begin
    col       = {collect[39:0], byte_in};
    count_inc = byte_count + 3'd1;
    skip_dec  = skip_remaining - 16'd1;

    phase_next          = phase;
    window_next         = window;
    byte_count_next     = byte_count;
    skip_remaining_next = skip_remaining;
    spu_position_next   = spu_position;
    data_size_next      = data_size;
    seq_start_next      = seq_start;
    is_last_next        = is_last;
    collect_next        = collect;
    command_next        = command;
    ev_next             = '0;
    ev_valid_next       = 1'b0;

    if (byte_valid) begin
      if (phase != PH_SCAN && phase != PH_PESHDR && phase != PH_HDRSKIP &&
          phase != PH_SUBID) begin
        spu_position_next = spu_position + 16'd1;
      end
      unique case (phase)
        PH_SCAN: begin
          if (window == 24'h000001) begin
            window_next = 24'hFFFFFF;
            if (byte_in == SID_PRIV1) begin
              phase_next      = PH_PESHDR;
              byte_count_next = 3'd0;
              collect_next    = '0;
            end
          end else begin
            window_next = {window[15:0], byte_in};
          end
        end
        PH_PESHDR: begin
          collect_next    = col;
          byte_count_next = count_inc;
          if (count_inc == 3'd5) begin
            byte_count_next     = 3'd0;
            collect_next        = '0;
            skip_remaining_next = {8'd0, byte_in};
            phase_next          = (byte_in != 8'd0) ? PH_HDRSKIP : PH_SUBID;
            ev_next.kind        = EV_PRIV1;
            ev_next.a           = col[39:24];
            ev_next.b           = {8'd0, byte_in};
            ev_valid_next       = 1'b1;
          end
        end
        PH_HDRSKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 16'd0) phase_next = PH_SUBID;
        end
        PH_SUBID: begin
          if (byte_in[7:5] == 3'b001) begin
            phase_next        = PH_SPUSIZE;
            spu_position_next = 16'd0;
            byte_count_next   = 3'd0;
            collect_next      = '0;
          end else begin
            phase_next  = PH_SCAN;
            window_next = 24'hFFFFFF;
          end
          ev_next.kind  = EV_SUBID;
          ev_next.a     = {8'd0, byte_in};
          ev_valid_next = 1'b1;
        end
        PH_SPUSIZE: begin
          collect_next    = col;
          byte_count_next = count_inc;
          if (count_inc == 3'd2) begin
            byte_count_next = 3'd0;
            collect_next    = '0;
            ev_valid_next   = 1'b1;
            if (col[15:0] == 16'd0) begin
              phase_next   = PH_SCAN;
              window_next  = 24'hFFFFFF;
              ev_next.kind = EV_ERROR;
              ev_next.a    = ERR_SPU_ZERO;
            end else begin
              phase_next   = PH_DATASIZE;
              ev_next.kind = EV_SPUSIZE;
              ev_next.a    = col[15:0];
            end
          end
        end
        PH_DATASIZE: begin
          collect_next    = col;
          byte_count_next = count_inc;
          if (count_inc == 3'd2) begin
            byte_count_next = 3'd0;
            collect_next    = '0;
            ev_valid_next   = 1'b1;
            if (col[15:2] == 14'd0) begin
              phase_next   = PH_SCAN;
              window_next  = 24'hFFFFFF;
              ev_next.kind = EV_ERROR;
              ev_next.a    = ERR_DATA_SMALL;
            end else begin
              data_size_next      = col[15:0];
              skip_remaining_next = col[15:0] - 16'd4;
              phase_next   = (col[15:0] != 16'd4) ? PH_DATA : PH_SEQHDR;
              ev_next.kind = EV_DSIZE;
              ev_next.a    = col[15:0];
            end
          end
        end
        PH_DATA: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_next      = PH_SEQHDR;
            byte_count_next = 3'd0;
            collect_next    = '0;
          end
          ev_next.kind  = EV_DATA;
          ev_next.a     = {8'd0, byte_in};
          ev_next.b     = data_size - 16'd4 - skip_remaining;
          ev_valid_next = 1'b1;
        end
        PH_SEQHDR: begin
          if (byte_count == 3'd0) seq_start_next = spu_position;
          collect_next    = col;
          byte_count_next = count_inc;
          if (count_inc == 3'd4) begin
            is_last_next    = (col[15:0] == seq_start);
            byte_count_next = 3'd0;
            collect_next    = '0;
            phase_next      = PH_CMD;
            ev_next.kind    = EV_SEQ;
            ev_next.a       = col[31:16];
            ev_next.b       = col[15:0];
            ev_valid_next   = 1'b1;
          end
        end
        PH_CMD: begin
          command_next = byte_in;
          if (param_len(byte_in) != 3'd0) begin
            byte_count_next = 3'd0;
            collect_next    = '0;
            phase_next      = PH_CMDPAR;
          end else begin
            ev_valid_next = 1'b1;
            case (byte_in)
              CMD_DISPLAY: ev_next.kind = EV_DISPLAY;
              CMD_STOP:    ev_next.kind = EV_STOP;
              CMD_END: begin
                ev_next.kind = EV_SEQEND;
                ev_next.last = is_last;
                if (is_last) begin
                  phase_next  = PH_SCAN;
                  window_next = 24'hFFFFFF;
                end else begin
                  phase_next      = PH_SEQHDR;
                  byte_count_next = 3'd0;
                  collect_next    = '0;
                end
              end
              default: begin
                ev_next.kind = EV_UNKNOWN;
                ev_next.a    = {8'd0, byte_in};
              end
            endcase
          end
        end
        PH_CMDPAR: begin
          collect_next    = col;
          byte_count_next = count_inc;
          if (count_inc == param_len(command)) begin
            phase_next    = PH_CMD;
            ev_valid_next = 1'b1;
            case (command)
              CMD_COLORS, CMD_CONTR: begin
                ev_next.kind = (command == CMD_COLORS) ? EV_COLORS : EV_CONTR;
                ev_next.a    = {12'd0, col[15:12]};
                ev_next.b    = {12'd0, col[11:8]};
                ev_next.c    = {12'd0, col[7:4]};
                ev_next.d    = {12'd0, col[3:0]};
              end
              CMD_AREA: begin
                ev_next.kind = EV_AREA;
                ev_next.a    = {4'd0, col[47:36]};
                ev_next.b    = {4'd0, col[35:24]};
                ev_next.c    = {4'd0, col[23:12]};
                ev_next.d    = {4'd0, col[11:0]};
              end
              CMD_PIXOFS: begin
                ev_next.kind = EV_PIXOFS;
                ev_next.a    = col[31:16];
                ev_next.b    = col[15:0];
              end
              default: begin
                ev_next.kind        = EV_COLCON;
                ev_next.a           = col[15:0];
                skip_remaining_next = col[15:0];
                if (col[15:0] != 16'd0) phase_next = PH_COLSKIP;
              end
            endcase
          end
        end
        PH_COLSKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 16'd0) phase_next = PH_CMD;
        end
        default: begin
          phase_next  = PH_SCAN;
          window_next = 24'hFFFFFF;
        end
      endcase
    end
  end

  // Parser state and the registered event.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SCAN;
      window         <= 24'hFFFFFF;
      byte_count     <= '0;
      skip_remaining <= '0;
      spu_position   <= '0;
      data_size      <= '0;
      seq_start      <= '0;
      is_last        <= 1'b0;
      collect        <= '0;
      command        <= '0;
      ev_valid       <= 1'b0;
    end else begin
      phase          <= phase_next;
      window         <= window_next;
      byte_count     <= byte_count_next;
      skip_remaining <= skip_remaining_next;
      spu_position   <= spu_position_next;
      data_size      <= data_size_next;
      seq_start      <= seq_start_next;
      is_last        <= is_last_next;
      collect        <= collect_next;
      command        <= command_next;
      ev_valid       <= ev_valid_next;
    end
    ev <= ev_next;
  end

endmodule
`default_nettype wire

[sv/dsp_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_queue
// Small event queue between the parser and the result port.
// ----------------------------------------------------------------------------
module dsp_queue #(
  parameter int Depth = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  dsp_pkg::event_t wr_data,
  output logic            almost_full,
  output logic            empty,
  input  wire logic       rd_en,
  output dsp_pkg::event_t rd_data
);
  import dsp_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  event_t          mem [Depth];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;
  logic            do_wr, do_rd;

  assign do_wr = wr_en;
  assign do_rd = rd_en && !empty;
  assign empty = (count == '0);
  // One slot stays free for the event still held in the parser register.
  assign almost_full = (count >= (AW+1)'(Depth - 1));
  assign rd_data = mem[rd_ptr];

  // Pointer and occupancy update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + AW'(1);
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

endmodule
`default_nettype wire

[sv/dsp_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_checker
// Port-level checks of the parser's result queue.
// ----------------------------------------------------------------------------
module dsp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [3:0]  event_kind,
  input wire logic [15:0] param_a,
  input wire logic        last_sequence
);
  import dsp_pkg::*;

  // A final-sequence flag only comes with a sequence-end event.
  a_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_sequence) |-> (event_kind == EV_SEQEND))
    else $error("last_sequence on a non sequence-end event");

  // Error events carry a known error code.
  a_err: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_kind == EV_ERROR) |->
      (param_a == ERR_SPU_ZERO || param_a == ERR_DATA_SMALL))
    else $error("bad error code");

  // A waiting result stays put until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(event_kind) && $stable(param_a)))
    else $error("result changed while stalled");

  // After reset the queue is empty.
  a_reset: assert property (@(posedge clk) $past(rst) |-> (empty && !full))
    else $error("queue not empty after reset");
endmodule

bind dvd_subpicture_stream_parser dsp_checker u_checker (
  .clk(clk), .rst(rst), .full(full), .empty(empty), .pop(pop),
  .event_kind(event_kind), .param_a(param_a), .last_sequence(last_sequence)
);
`default_nettype wire
